[sv/svd_pkg.sv]
// Shared types, constants and state encodings for the surface vector decomposition block.
package svd_pkg;

    localparam int COORD_BITS = 24;
    localparam int OUT_BITS   = 32;
    localparam int SUM_BITS   = 64;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [OUT_BITS-1:0]   t_comp;
    typedef logic signed [SUM_BITS-1:0]   t_sum;

    localparam logic OP_CELL   = 1'b0;
    localparam logic OP_VECTOR = 1'b1;

    localparam t_sum SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_sum SUM_MIN = 64'sh8000_0000_0000_0001;

    typedef struct packed {
        logic   opcode;
        logic   cell_supported;
        t_coord corner_a_x;
        t_coord corner_a_y;
        t_coord corner_a_z;
        t_coord corner_b_x;
        t_coord corner_b_y;
        t_coord corner_b_z;
        t_coord corner_c_x;
        t_coord corner_c_y;
        t_coord corner_c_z;
    } t_in_word;

    typedef struct packed {
        t_comp par_x;
        t_comp par_y;
        t_comp par_z;
        t_comp perp_x;
        t_comp perp_y;
        t_comp perp_z;
        logic  bad_cell;
        logic  zero_normal;
    } t_out_word;

    // One closed point handed from the front to the back.
    typedef struct packed {
        t_sum   sum_x;
        t_sum   sum_y;
        t_sum   sum_z;
        logic   bad_cell;
        t_coord vec_x;
        t_coord vec_y;
        t_coord vec_z;
    } t_point;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic [2:0] {
        F_IDLE,
        F_EDGE,
        F_MUL,
        F_ADD,
        F_PUSH
    } t_front_state;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MAX,
        B_NORM,
        B_SQ_MUL,
        B_SQ_ADD,
        B_SQRT,
        B_DIV_SETUP,
        B_DIV,
        B_DOT_MUL,
        B_DOT_ADD,
        B_RND,
        B_PRJ_MUL,
        B_PRJ_ADD,
        B_OUT
    } t_back_state;

endpackage

[sv/svd_front.sv]
// Front part: accepts words, accumulates cell cross products and hands off closed points.
module svd_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  svd_pkg::t_in_word     i_in_data,
    input  svd_pkg::t_queue_status i_q_status,
    output logic                  o_push,
    output svd_pkg::t_point       o_point
);

    localparam int EW = svd_pkg::COORD_BITS + 1;
    localparam logic signed [svd_pkg::SUM_BITS:0] WIDE_MAX =
        (svd_pkg::SUM_BITS+1)'(svd_pkg::SUM_MAX);
    localparam logic signed [svd_pkg::SUM_BITS:0] WIDE_MIN =
        (svd_pkg::SUM_BITS+1)'(svd_pkg::SUM_MIN);

    svd_pkg::t_front_state r_state, n_state;
    svd_pkg::t_in_word     r_item;
    logic signed [EW-1:0]  r_e1 [3];
    logic signed [EW-1:0]  r_e2 [3];
    svd_pkg::t_sum         r_p1, r_p2;
    svd_pkg::t_sum         r_sum [3];
    logic [1:0]            r_axis;
    logic                  r_err;

    logic                  w_accept;
    logic signed [EW-1:0]  w_m1a, w_m1b, w_m2a, w_m2b;
    logic signed [2*EW-1:0] w_prod1, w_prod2;
    svd_pkg::t_sum         w_term;
    logic signed [svd_pkg::SUM_BITS:0] w_wide;
    svd_pkg::t_sum         w_sat;

    assign w_accept = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            svd_pkg::F_IDLE: begin
                if (w_accept) begin
                    if (i_in_data.opcode == svd_pkg::OP_VECTOR) begin
                        n_state = svd_pkg::F_PUSH;
                    end else if (i_in_data.cell_supported) begin
                        n_state = svd_pkg::F_EDGE;
                    end
                end
            end
            svd_pkg::F_EDGE: n_state = svd_pkg::F_MUL;
            svd_pkg::F_MUL:  n_state = svd_pkg::F_ADD;
            svd_pkg::F_ADD: begin
                n_state = (r_axis == 2'd2) ? svd_pkg::F_IDLE : svd_pkg::F_MUL;
            end
            svd_pkg::F_PUSH: begin
                if (!i_q_status.full) begin
                    n_state = svd_pkg::F_IDLE;
                end
            end
            default: n_state = svd_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == svd_pkg::F_IDLE);
        o_push     = (r_state == svd_pkg::F_PUSH) && !i_q_status.full;
    end

    // Operand pairs of the cross product (B-A) x (C-A), one axis at a time.
    always_comb begin
        case (r_axis)
            2'd1: begin
                w_m1a = r_e2[0]; w_m1b = r_e1[2];
                w_m2a = r_e1[0]; w_m2b = r_e2[2];
            end
            2'd2: begin
                w_m1a = r_e1[0]; w_m1b = r_e2[1];
                w_m2a = r_e2[0]; w_m2b = r_e1[1];
            end
            default: begin
                w_m1a = r_e1[1]; w_m1b = r_e2[2];
                w_m2a = r_e2[1]; w_m2b = r_e1[2];
            end
        endcase
        w_prod1 = w_m1a * w_m1b;
        w_prod2 = w_m2a * w_m2b;
        w_term  = r_p1 - r_p2;
        w_wide  = (svd_pkg::SUM_BITS+1)'(r_sum[r_axis]) + (svd_pkg::SUM_BITS+1)'(w_term);
        if (w_wide > WIDE_MAX) begin
            w_sat = svd_pkg::SUM_MAX;
        end else if (w_wide < WIDE_MIN) begin
            w_sat = svd_pkg::SUM_MIN;
        end else begin
            w_sat = w_wide[svd_pkg::SUM_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= svd_pkg::F_IDLE;
            r_axis  <= 2'd0;
            r_err   <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_item <= i_in_data;
                if (i_in_data.opcode == svd_pkg::OP_CELL && !i_in_data.cell_supported) begin
                    r_err <= 1'b1;
                end
            end
            if (r_state == svd_pkg::F_EDGE) begin
                r_e1[0] <= EW'(r_item.corner_b_x) - EW'(r_item.corner_a_x);
                r_e1[1] <= EW'(r_item.corner_b_y) - EW'(r_item.corner_a_y);
                r_e1[2] <= EW'(r_item.corner_b_z) - EW'(r_item.corner_a_z);
                r_e2[0] <= EW'(r_item.corner_c_x) - EW'(r_item.corner_a_x);
                r_e2[1] <= EW'(r_item.corner_c_y) - EW'(r_item.corner_a_y);
                r_e2[2] <= EW'(r_item.corner_c_z) - EW'(r_item.corner_a_z);
                r_axis  <= 2'd0;
            end
            if (r_state == svd_pkg::F_MUL) begin
                r_p1 <= svd_pkg::SUM_BITS'(w_prod1);
                r_p2 <= svd_pkg::SUM_BITS'(w_prod2);
            end
            if (r_state == svd_pkg::F_ADD) begin
                r_sum[r_axis] <= w_sat;
                r_axis        <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
            end
            if (o_push) begin
                r_err <= 1'b0;
                for (int i = 0; i < 3; i++) begin
                    r_sum[i] <= '0;
                end
            end
        end
    end

    always_comb begin
        o_point.sum_x    = r_sum[0];
        o_point.sum_y    = r_sum[1];
        o_point.sum_z    = r_sum[2];
        o_point.bad_cell = r_err;
        o_point.vec_x    = r_item.corner_a_x;
        o_point.vec_y    = r_item.corner_a_y;
        o_point.vec_z    = r_item.corner_a_z;
    end

endmodule

[sv/svd_queue.sv]
// Two-entry queue of closed points between the front and the back.
module svd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  svd_pkg::t_point        i_point,
    input  logic                   i_pop,
    output svd_pkg::t_point        o_point,
    output svd_pkg::t_queue_status o_status
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    svd_pkg::t_point   r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr, r_rd;
    logic [CNT_W-1:0]  r_count;

    assign o_point        = r_mem[r_rd];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr] <= i_point;
                r_wr        <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full) else $error("push into a full point queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty) else $error("pop from an empty point queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH)) else $error("point queue count out of range");

endmodule

[sv/svd_back.sv]
// Back part: normalizes the normal sum and splits the vector into normal and surface parts.
module svd_back #(
    parameter int VECTOR_BITS = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  svd_pkg::t_queue_status i_q_status,
    input  svd_pkg::t_point        i_point,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output svd_pkg::t_out_word     o_out_data
);

    localparam svd_pkg::t_sum SAT_HI = (64'sd1 <<< (VECTOR_BITS - 1)) - 64'sd1;
    localparam svd_pkg::t_sum SAT_LO = -SAT_HI - 64'sd1;
    localparam svd_pkg::t_sum RND_D  = 64'sd2097152;
    localparam svd_pkg::t_sum RND_P  = 64'sd536870912;

    function automatic svd_pkg::t_comp sat_vec(input svd_pkg::t_sum x);
        svd_pkg::t_sum c;
        c = (x > SAT_HI) ? SAT_HI : ((x < SAT_LO) ? SAT_LO : x);
        return svd_pkg::t_comp'(c);
    endfunction

    svd_pkg::t_back_state r_state, n_state;
    svd_pkg::t_sum   r_s [3];
    svd_pkg::t_coord r_v [3];
    svd_pkg::t_comp  r_par [3];
    svd_pkg::t_comp  r_perp [3];
    logic signed [31:0] r_n [3];
    logic            r_bad, r_zero;
    logic [63:0]     r_mx;
    logic [1:0]      r_idx;
    svd_pkg::t_sum   r_prod;
    logic [63:0]     r_sq, r_x, r_r, r_bit;
    logic [31:0]     r_m, r_rem, r_q;
    logic [60:0]     r_num;
    logic [5:0]      r_cnt;
    svd_pkg::t_sum   r_acc;
    logic signed [35:0] r_d;
    logic            r_out_valid;
    svd_pkg::t_out_word r_out;

    logic [63:0]     w_mag [3];
    logic [63:0]     w_max01;
    logic            w_all_zero;
    logic signed [31:0] w_ma;
    logic signed [35:0] w_mb;
    logic signed [67:0] w_mp;
    logic [63:0]     w_t, w_r_nx;
    logic            w_ge;
    logic [32:0]     w_rem_sh;
    logic            w_qbit;
    logic [31:0]     w_q_nx;
    svd_pkg::t_sum   w_p;
    logic            w_load;
    logic            w_last;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r_s[i][63] ? 64'(-r_s[i]) : 64'(r_s[i]);
        end
        w_max01    = (w_mag[1] > w_mag[0]) ? w_mag[1] : w_mag[0];
        w_all_zero = (r_s[0] == '0) && (r_s[1] == '0) && (r_s[2] == '0);
        w_last     = (r_idx == 2'd2);

        // One shared multiplier, operands chosen by the step in progress.
        case (r_state)
            svd_pkg::B_SQ_MUL: begin
                w_ma = r_s[r_idx][31:0];
                w_mb = 36'($signed(r_s[r_idx][31:0]));
            end
            svd_pkg::B_DOT_MUL: begin
                w_ma = r_n[r_idx];
                w_mb = 36'(r_v[r_idx]);
            end
            default: begin
                w_ma = r_n[r_idx];
                w_mb = r_d;
            end
        endcase
        w_mp = w_ma * w_mb;

        // Bitwise square root step.
        w_t    = r_r + r_bit;
        w_ge   = (r_x >= w_t);
        w_r_nx = w_ge ? ((r_r >> 1) + r_bit) : (r_r >> 1);

        // Restoring division step.
        w_rem_sh = {r_rem, r_num[60]};
        w_qbit   = (w_rem_sh >= {1'b0, r_m});
        w_q_nx   = {r_q[30:0], w_qbit};

        w_p = (r_prod + RND_P) >>> 30;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            svd_pkg::B_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = svd_pkg::B_MAX;
                end
            end
            svd_pkg::B_MAX: n_state = w_all_zero ? svd_pkg::B_OUT : svd_pkg::B_NORM;
            svd_pkg::B_NORM: begin
                if (r_mx[63:30] == '0) begin
                    n_state = svd_pkg::B_SQ_MUL;
                end
            end
            svd_pkg::B_SQ_MUL: n_state = svd_pkg::B_SQ_ADD;
            svd_pkg::B_SQ_ADD: n_state = w_last ? svd_pkg::B_SQRT : svd_pkg::B_SQ_MUL;
            svd_pkg::B_SQRT: begin
                if (r_bit[0]) begin
                    n_state = svd_pkg::B_DIV_SETUP;
                end
            end
            svd_pkg::B_DIV_SETUP: n_state = svd_pkg::B_DIV;
            svd_pkg::B_DIV: begin
                if (r_cnt == 6'd60) begin
                    n_state = w_last ? svd_pkg::B_DOT_MUL : svd_pkg::B_DIV_SETUP;
                end
            end
            svd_pkg::B_DOT_MUL: n_state = svd_pkg::B_DOT_ADD;
            svd_pkg::B_DOT_ADD: n_state = w_last ? svd_pkg::B_RND : svd_pkg::B_DOT_MUL;
            svd_pkg::B_RND:     n_state = svd_pkg::B_PRJ_MUL;
            svd_pkg::B_PRJ_MUL: n_state = svd_pkg::B_PRJ_ADD;
            svd_pkg::B_PRJ_ADD: n_state = w_last ? svd_pkg::B_OUT : svd_pkg::B_PRJ_MUL;
            svd_pkg::B_OUT: begin
                if (w_load) begin
                    n_state = svd_pkg::B_IDLE;
                end
            end
            default: n_state = svd_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = (r_state == svd_pkg::B_IDLE) && !i_q_status.empty;
        w_load = (r_state == svd_pkg::B_OUT) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= svd_pkg::B_IDLE;
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                svd_pkg::B_IDLE: begin
                    if (o_pop) begin
                        r_s[0] <= i_point.sum_x;
                        r_s[1] <= i_point.sum_y;
                        r_s[2] <= i_point.sum_z;
                        r_v[0] <= i_point.vec_x;
                        r_v[1] <= i_point.vec_y;
                        r_v[2] <= i_point.vec_z;
                        r_bad  <= i_point.bad_cell;
                    end
                end
                svd_pkg::B_MAX: begin
                    r_zero <= w_all_zero;
                    r_mx   <= (w_mag[2] > w_max01) ? w_mag[2] : w_max01;
                    for (int i = 0; i < 3; i++) begin
                        r_par[i]  <= '0;
                        r_perp[i] <= '0;
                    end
                end
                svd_pkg::B_NORM: begin
                    if (r_mx[63:30] != '0) begin
                        r_mx <= r_mx >> 1;
                        for (int i = 0; i < 3; i++) begin
                            r_s[i] <= r_s[i] >>> 1;
                        end
                    end else begin
                        r_idx <= 2'd0;
                        r_sq  <= '0;
                    end
                end
                svd_pkg::B_SQ_MUL, svd_pkg::B_DOT_MUL, svd_pkg::B_PRJ_MUL: begin
                    r_prod <= svd_pkg::SUM_BITS'(w_mp);
                end
                svd_pkg::B_SQ_ADD: begin
                    r_sq <= r_sq + r_prod;
                    if (w_last) begin
                        r_x   <= r_sq + r_prod;
                        r_r   <= '0;
                        r_bit <= 64'd1 << 62;
                        r_idx <= 2'd0;
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                svd_pkg::B_SQRT: begin
                    if (w_ge) begin
                        r_x <= r_x - w_t;
                    end
                    r_r   <= w_r_nx;
                    r_bit <= r_bit >> 2;
                    r_m   <= (w_r_nx == '0) ? 32'd1 : w_r_nx[31:0];
                end
                svd_pkg::B_DIV_SETUP: begin
                    r_num <= {w_mag[r_idx][30:0], 30'd0} + 61'(r_m >> 1);
                    r_rem <= '0;
                    r_q   <= '0;
                    r_cnt <= '0;
                end
                svd_pkg::B_DIV: begin
                    r_rem <= w_qbit ? 32'(w_rem_sh - {1'b0, r_m}) : w_rem_sh[31:0];
                    r_q   <= w_q_nx;
                    r_num <= r_num << 1;
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd60) begin
                        r_n[r_idx] <= r_s[r_idx][63] ? -$signed(w_q_nx) : $signed(w_q_nx);
                        r_idx      <= w_last ? 2'd0 : r_idx + 2'd1;
                        r_acc      <= '0;
                    end
                end
                svd_pkg::B_DOT_ADD: begin
                    r_acc <= r_acc + (r_prod >>> 8);
                    r_idx <= w_last ? 2'd0 : r_idx + 2'd1;
                end
                svd_pkg::B_RND: begin
                    r_d <= 36'((r_acc + RND_D) >>> 22);
                end
                svd_pkg::B_PRJ_ADD: begin
                    r_perp[r_idx] <= sat_vec(w_p);
                    r_par[r_idx]  <= sat_vec(svd_pkg::t_sum'(r_v[r_idx]) - w_p);
                    r_idx         <= w_last ? 2'd0 : r_idx + 2'd1;
                end
                default: begin
                end
            endcase
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out.par_x       <= r_par[0];
            r_out.par_y       <= r_par[1];
            r_out.par_z       <= r_par[2];
            r_out.perp_x      <= r_perp[0];
            r_out.perp_y      <= r_perp[1];
            r_out.perp_z      <= r_perp[2];
            r_out.bad_cell    <= r_bad;
            r_out.zero_normal <= r_zero;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_zero_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.zero_normal) |->
        (o_out_data.par_x == '0 && o_out_data.par_y == '0 && o_out_data.par_z == '0 &&
         o_out_data.perp_x == '0 && o_out_data.perp_y == '0 && o_out_data.perp_z == '0))
        else $error("zero normal word carries nonzero components");
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svd_pkg::B_DIV) |-> (r_m != '0)) else $error("divide by zero norm");
    a_sqrt_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == svd_pkg::B_SQRT) |-> $onehot(r_bit)) else $error("square root bit lost");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_state == svd_pkg::B_MAX)) else $error("pop did not start a point");

endmodule

[sv/surface_vector_decompose.sv]
// Top level of the surface vector decomposition block: front, point queue and back.
//
//  Channel  Direction  Handshake                    Word
//  input    in         i_in_valid / o_in_ready      svd_pkg::t_in_word  (i_in_data)
//  output   out        o_out_valid / i_out_ready    svd_pkg::t_out_word (o_out_data)
//
// A supported cell word occupies the front for the accept, the edge subtract, then a
// multiply and a saturating add for each axis; an unsupported cell word is only accepted.
// A vector word is accepted and then pushed once the queue is not full. The back runs up to
// 33 normalizing shifts, the 32-step square root and the divider once for each component;
// a zero normal goes from the maximum search straight to the output.
// Reset is synchronous and active low; it clears the sums, the error flag, the queue and
// the output valid flag. The front keeps accumulating the next point while the back works,
// and the back finishes a point while a result word still waits at the output.
module surface_vector_decompose #(
    parameter int VECTOR_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  svd_pkg::t_in_word  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output svd_pkg::t_out_word o_out_data
);

    // Handoff between the parts: one closed point per queue entry.
    logic                   w_push;
    logic                   w_pop;
    svd_pkg::t_point        w_push_point;
    svd_pkg::t_point        w_pop_point;
    svd_pkg::t_queue_status w_q_status;

    // The front accumulates cross products and closes a point on a vector word.
    svd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_point    (w_push_point)
    );

    // The queue lets the front and the back stall independently.
    svd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_point  (w_push_point),
        .i_pop    (w_pop),
        .o_point  (w_pop_point),
        .o_status (w_q_status)
    );

    // The back normalizes the sum and projects the vector onto the unit normal.
    svd_back #(
        .VECTOR_BITS (VECTOR_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_status  (w_q_status),
        .i_point     (w_pop_point),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
